[hdl/ppc_pkg.sv]
// ppc_pkg: shared types, opcodes and constants for the pinned page cache
// depends on nothing; used by ppc_ctrl, ppc_dpath and pinned_page_cache_lru
package ppc_pkg;

	localparam int TableEntriesDefault = 16;
	localparam int PoolLimitReset = 16;

	localparam logic [2:0] OP_GET = 3'd0;
	localparam logic [2:0] OP_RELEASE = 3'd1;
	localparam logic [2:0] OP_DIRTY = 3'd2;
	localparam logic [2:0] OP_FLUSH = 3'd3;
	localparam logic [2:0] OP_COUNT = 3'd4;
	localparam logic [2:0] OP_STAT = 3'd5;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_BADSLOT = 2'd2;

	localparam logic [1:0] SEL_HITS = 2'd0;
	localparam logic [1:0] SEL_MISSES = 2'd1;
	localparam logic [1:0] SEL_WRITES = 2'd2;
	localparam logic [1:0] SEL_EVICTS = 2'd3;

	typedef struct packed {
		logic [2:0] opcode;
		logic [31:0] segment;
		logic [31:0] page_number;
		logic [7:0] page_kind;
		logic [3:0] slot_index;
		logic [1:0] stat_select;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic hit;
		logic [3:0] slot;
		logic [15:0] pin_count;
		logic dirty;
		logic [63:0] value;
		logic evicted;
		logic writeback;
		logic [31:0] evicted_segment;
		logic [31:0] evicted_page;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // capture request, clear scan results
		logic clr_idx; // restart entry scan
		logic step;    // evaluate one entry, advance index
		logic finish;  // apply the operation, build the result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last; // current entry is the last one
		logic need_scan; // captured op walks the table
	} sts_t;

endpackage

[hdl/ppc_ctrl.sv]
// ppc_ctrl: sequencer for the page cache, one item at a time
// depends on ppc_pkg
module ppc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic out_fire,
	input ppc_pkg::sts_t sts,
	output ppc_pkg::cmd_t cmd,
	output logic busy,
	output logic out_valid
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;
	localparam logic [1:0] S_OUT = 2'd3;

	logic [1:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					cmd.load = 1'b1;
					cmd.clr_idx = 1'b1;
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (!sts.need_scan) begin
					state_d = S_DONE;
				end else begin
					cmd.step = 1'b1;
					if (sts.scan_last) state_d = S_DONE;
				end
			end
			S_DONE: begin
				cmd.finish = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_fire) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hdl/ppc_dpath.sv]
// ppc_dpath: descriptor table, counters and scan logic of the page cache
// depends on ppc_pkg
module ppc_dpath #(
	parameter int TABLE_ENTRIES = ppc_pkg::TableEntriesDefault
) (
	input logic clk,
	input logic arst_n,
	input ppc_pkg::req_t req,
	input ppc_pkg::cmd_t cmd,
	input logic cfg_we,
	input logic [4:0] cfg_data,
	output ppc_pkg::sts_t sts,
	output ppc_pkg::rsp_t rsp
);

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	logic [TABLE_ENTRIES-1:0] valid_q, dirty_q;
	logic [15:0] pins_q [TABLE_ENTRIES];
	logic [31:0] seg_q [TABLE_ENTRIES];
	logic [31:0] page_q [TABLE_ENTRIES];
	logic [7:0] kind_q [TABLE_ENTRIES];
	logic [31:0] last_q [TABLE_ENTRIES];
	logic [CW-1:0] resident_q;
	logic [31:0] clock_q;
	logic [63:0] hits_q, misses_q, writes_q, evicts_q;
	logic [4:0] limit_q;

	ppc_pkg::req_t req_q;
	logic [IW-1:0] idx_q;
	logic found_q, free_ok_q, vic_ok_q;
	logic [IW-1:0] found_idx_q, free_idx_q, vic_idx_q;
	logic [31:0] vic_use_q;
	logic [CW-1:0] n_q;
	ppc_pkg::rsp_t rsp_q;
	ppc_pkg::rsp_t rsp_d;

	// effective limit clamped to [1, TABLE_ENTRIES]
	logic [CW:0] lim;
	always_comb begin
		if (limit_q == 5'd0) lim = (CW+1)'(1);
		else if (32'(limit_q) > 32'(TABLE_ENTRIES))
			lim = (CW+1)'(TABLE_ENTRIES);
		else lim = (CW+1)'(limit_q);
	end

	logic seg_match;
	assign seg_match = (req_q.segment == 32'd0) || (seg_q[idx_q] == req_q.segment);

	assign sts.scan_last = (idx_q == IW'(TABLE_ENTRIES - 1));
	assign sts.need_scan = (req_q.opcode == ppc_pkg::OP_GET) ||
		(req_q.opcode == ppc_pkg::OP_FLUSH) || (req_q.opcode == ppc_pkg::OP_COUNT);
	assign rsp = rsp_q;

	logic slot_ok;
	logic [IW-1:0] si;
	assign slot_ok = ({28'd0, req_q.slot_index} < 32'(TABLE_ENTRIES)) && valid_q[si];
	assign si = IW'(req_q.slot_index);

	logic evict, full;
	logic [IW-1:0] tgt;
	always_comb begin
		evict = 1'b0;
		full = 1'b0;
		tgt = free_idx_q;
		if (({1'b0, resident_q} >= lim) || !free_ok_q) begin
			if (vic_ok_q) begin
				evict = 1'b1;
				tgt = vic_idx_q;
			end else begin
				full = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			dirty_q <= '0;
			for (int i = 0; i < TABLE_ENTRIES; i++) pins_q[i] <= 16'd0;
			resident_q <= '0;
			clock_q <= 32'd0;
			hits_q <= 64'd0;
			misses_q <= 64'd0;
			writes_q <= 64'd0;
			evicts_q <= 64'd0;
			limit_q <= 5'(ppc_pkg::PoolLimitReset);
		end else begin
			if (cfg_we) limit_q <= cfg_data;
			if (cmd.step && req_q.opcode == ppc_pkg::OP_FLUSH && valid_q[idx_q] &&
					dirty_q[idx_q] && seg_match)
				dirty_q[idx_q] <= 1'b0;
			if (cmd.finish) begin
				unique case (req_q.opcode)
					ppc_pkg::OP_GET: begin
						clock_q <= clock_q + 32'd1;
						if (found_q) begin
							hits_q <= hits_q + 64'd1;
							if (pins_q[found_idx_q] != 16'hFFFF)
								pins_q[found_idx_q] <= pins_q[found_idx_q] + 16'd1;
						end else begin
							misses_q <= misses_q + 64'd1;
							if (!full) begin
								if (evict) begin
									evicts_q <= evicts_q + 64'd1;
									if (dirty_q[tgt]) writes_q <= writes_q + 64'd1;
								end else begin
									resident_q <= resident_q + CW'(1);
								end
								valid_q[tgt] <= 1'b1;
								dirty_q[tgt] <= 1'b0;
								pins_q[tgt] <= 16'd1;
							end
						end
					end
					ppc_pkg::OP_RELEASE: begin
						if (slot_ok && pins_q[si] != 16'd0) pins_q[si] <= pins_q[si] - 16'd1;
					end
					ppc_pkg::OP_DIRTY: begin
						if (slot_ok) dirty_q[si] <= 1'b1;
					end
					ppc_pkg::OP_FLUSH: writes_q <= writes_q + 64'(n_q);
					default: ;
				endcase
			end
		end
	end

	// key and stamp stores, no reset
	always_ff @(posedge clk) begin
		if (cmd.finish && req_q.opcode == ppc_pkg::OP_GET) begin
			if (found_q) begin
				last_q[found_idx_q] <= clock_q;
			end else if (!full) begin
				seg_q[tgt] <= req_q.segment;
				page_q[tgt] <= req_q.page_number;
				kind_q[tgt] <= req_q.page_kind;
				last_q[tgt] <= clock_q;
			end
		end
	end

	// result of the captured operation, from the scan results, slot state or counters
	always_comb begin
		rsp_d = '0;
		unique case (req_q.opcode) inside
			ppc_pkg::OP_GET: begin
				if (found_q) begin
					rsp_d.hit = 1'b1;
					rsp_d.slot = 4'(found_idx_q);
					rsp_d.pin_count = (pins_q[found_idx_q] != 16'hFFFF) ?
						pins_q[found_idx_q] + 16'd1 : 16'hFFFF;
					rsp_d.dirty = dirty_q[found_idx_q];
				end else if (full) begin
					rsp_d.status = ppc_pkg::ST_FULL;
				end else begin
					rsp_d.slot = 4'(tgt);
					rsp_d.pin_count = 16'd1;
					if (evict) begin
						rsp_d.evicted = 1'b1;
						rsp_d.writeback = dirty_q[tgt];
						rsp_d.evicted_segment = seg_q[tgt];
						rsp_d.evicted_page = page_q[tgt];
					end
				end
			end
			ppc_pkg::OP_RELEASE, ppc_pkg::OP_DIRTY: begin
				rsp_d.slot = req_q.slot_index;
				if (!slot_ok) begin
					rsp_d.status = ppc_pkg::ST_BADSLOT;
				end else if (req_q.opcode == ppc_pkg::OP_RELEASE) begin
					rsp_d.pin_count = (pins_q[si] != 16'd0) ? pins_q[si] - 16'd1 : 16'd0;
					rsp_d.dirty = dirty_q[si];
				end else begin
					rsp_d.pin_count = pins_q[si];
					rsp_d.dirty = 1'b1;
				end
			end
			ppc_pkg::OP_FLUSH, ppc_pkg::OP_COUNT: rsp_d.value = 64'(n_q);
			ppc_pkg::OP_STAT: begin
				unique case (req_q.stat_select)
					ppc_pkg::SEL_HITS: rsp_d.value = hits_q;
					ppc_pkg::SEL_MISSES: rsp_d.value = misses_q;
					ppc_pkg::SEL_WRITES: rsp_d.value = writes_q;
					ppc_pkg::SEL_EVICTS: rsp_d.value = evicts_q;
					default: rsp_d.value = evicts_q;
				endcase
			end
			default: ;
		endcase
	end

	// request capture, scan and result
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
			found_q <= 1'b0;
			free_ok_q <= 1'b0;
			vic_ok_q <= 1'b0;
			n_q <= '0;
		end
		if (cmd.clr_idx) idx_q <= '0;
		if (cmd.step) begin
			idx_q <= idx_q + IW'(1);
			if (valid_q[idx_q]) begin
				if (!found_q && seg_q[idx_q] == req_q.segment &&
						page_q[idx_q] == req_q.page_number &&
						kind_q[idx_q] == req_q.page_kind) begin
					found_q <= 1'b1;
					found_idx_q <= idx_q;
				end
				if (pins_q[idx_q] == 16'd0 && (!vic_ok_q || last_q[idx_q] < vic_use_q)) begin
					vic_ok_q <= 1'b1;
					vic_idx_q <= idx_q;
					vic_use_q <= last_q[idx_q];
				end
				if (dirty_q[idx_q] && seg_match) n_q <= n_q + CW'(1);
			end else if (!free_ok_q) begin
				free_ok_q <= 1'b1;
				free_idx_q <= idx_q;
			end
		end
		if (cmd.finish) rsp_q <= rsp_d;
	end

endmodule

[hdl/pinned_page_cache_lru.sv]
// pinned_page_cache_lru: top level of the pinned page-descriptor cache
// depends on ppc_pkg, ppc_ctrl, ppc_dpath
//
// usage:
//  - s_axis carries one request item; m_axis returns exactly one result item
//    per request, in order
//  - cfg_we/cfg_data write pool_limit (reset 16); write only while idle
//  - get, flush and count_dirty walk the table one entry per cycle before
//    the result is built
//  - release, mark_dirty, read_stat and unknown opcodes skip the walk and
//    go from the scan state straight to building the result
//  - one item is in flight at a time; s_axis_tready drops after accept and
//    rises again in the cycle after the result item has been taken, so no
//    new request is taken while one is in progress
//  - the result register holds while m_axis_tready is low; a stall delays
//    the next accept
//  - reset clears valid, dirty and pin state, counters and the access clock;
//    no clearing pass, the block is ready right after reset
module pinned_page_cache_lru #(
	parameter int TABLE_ENTRIES = ppc_pkg::TableEntriesDefault
) (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	output logic s_axis_tready,
	// opcode[2:0], segment[34:3], page_number[66:35], page_kind[74:67],
	// slot_index[78:75], stat_select[80:79], zero pad to 88
	input logic [87:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input logic m_axis_tready,
	// status[1:0], hit[2], slot[6:3], pin_count[22:7], dirty[23], value[87:24],
	// evicted[88], writeback[89], evicted_segment[121:90],
	// evicted_page[153:122], zero pad to 160
	output logic [159:0] m_axis_tdata,
	input logic cfg_we,
	input logic [4:0] cfg_data
);

	ppc_pkg::cmd_t cmd;
	ppc_pkg::sts_t sts;
	ppc_pkg::req_t req;
	ppc_pkg::rsp_t rsp;
	logic busy;
	logic in_fire, out_fire;

	assign s_axis_tready = !busy;
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign out_fire = m_axis_tvalid && m_axis_tready;

	// unpack the request item
	assign req.opcode = s_axis_tdata[2:0];
	assign req.segment = s_axis_tdata[34:3];
	assign req.page_number = s_axis_tdata[66:35];
	assign req.page_kind = s_axis_tdata[74:67];
	assign req.slot_index = s_axis_tdata[78:75];
	assign req.stat_select = s_axis_tdata[80:79];

	// pack the result item
	assign m_axis_tdata = {6'd0, rsp.evicted_page, rsp.evicted_segment, rsp.writeback,
		rsp.evicted, rsp.value, rsp.dirty, rsp.pin_count, rsp.slot, rsp.hit, rsp.status};

	ppc_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.out_fire(out_fire),
		.sts(sts),
		.cmd(cmd),
		.busy(busy),
		.out_valid(m_axis_tvalid)
	);

	ppc_dpath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.cmd(cmd),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.sts(sts),
		.rsp(rsp)
	);

endmodule

[hdl/ppc_checker.sv]
// ppc_checker: port-level assertions for the pinned page cache
// depends on pinned_page_cache_lru ports only; bound below
module ppc_checker (
	input logic clk,
	input logic arst_n,
	input logic s_axis_tvalid,
	input logic s_axis_tready,
	input logic m_axis_tvalid,
	input logic m_axis_tready,
	input logic [159:0] m_axis_tdata
);

	// one item in flight: no accept while a result waits
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept while result pending");

	// an accepted item never yields a result in the next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid) else $error("result too early");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result dropped under stall");

	// a hit never reports an eviction
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[2]) |-> !m_axis_tdata[88]) else $error("hit with evict");

endmodule

bind pinned_page_cache_lru ppc_checker u_ppc_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata)
);
